/* design/fpba_pkg.sv */
// Shared types, constants and selection function for the fit policy block allocator.
package fpba_pkg;

   localparam int MAX_BLOCKS = 16;
   localparam int SIZE_BITS  = 16;
   localparam int LANES      = 4;
   localparam int GROUPS     = MAX_BLOCKS / LANES;
   localparam int BLK_W      = $clog2(MAX_BLOCKS);
   localparam int COUNT_W    = 5;
   localparam int MODE_W     = 2;
   localparam int SLOT_W     = 4;
   localparam int VALUE_W    = 16;
   localparam int NUM_W      = 16;
   localparam int CSR_W      = 5;
   localparam int CSR_IDX_W  = 1;

   localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
   localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_FIT_MODE    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_COUNT = 1'd1;

   localparam logic CMD_LOAD    = 1'b0;
   localparam logic CMD_REQUEST = 1'b1;

   typedef struct packed {
      logic [MODE_W-1:0]  fit_mode;
      logic [COUNT_W-1:0] block_count;
   } cfg_type;

   // classified word handed from front to back
   typedef struct packed {
      logic                 is_request;
      logic [SLOT_W-1:0]    slot;
      logic [SIZE_BITS-1:0] size;
      logic [NUM_W-1:0]     number;
   } work_type;

   typedef struct packed {
      logic                 valid;
      logic [BLK_W-1:0]     idx;
      logic [SIZE_BITS-1:0] size;
   } cand_type;

   // a is the lower index; b replaces it only when strictly better
   function automatic cand_type pick_better(cand_type a, cand_type b,
                                            logic [MODE_W-1:0] mode);
      cand_type r;
      r = a;
      if (!a.valid) begin
         r = b;
      end else if (b.valid) begin
         if (mode == MODE_WORST && b.size > a.size) begin
            r = b;
         end else if (mode == MODE_BEST && b.size < a.size) begin
            r = b;
         end
      end
      return r;
   endfunction

endpackage

/* design/fpba_if.sv */
// Request and response channel interfaces.
interface fpba_req_if import fpba_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               command;
   logic [SLOT_W-1:0]  block_slot;
   logic [VALUE_W-1:0] size_value;

   modport source (output valid, command, block_slot, size_value, input ready);
   modport sink   (input valid, command, block_slot, size_value, output ready);
endinterface

interface fpba_rsp_if import fpba_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              granted;
   logic [SLOT_W-1:0] chosen_block;
   logic [NUM_W-1:0]  request_number;

   modport source (output valid, granted, chosen_block, request_number, input ready);
   modport sink   (input valid, granted, chosen_block, request_number, output ready);
endinterface

/* design/fpba_front.sv */
// Front end: accepts request words, classifies them and numbers allocation requests.
module fpba_front import fpba_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   fpba_req_if.sink    req_if,
   output logic        push_valid,
   output work_type    push_word,
   input  logic        push_ready
);

   logic             stage_valid_ff, stage_valid_in;
   work_type         stage_word_ff, stage_word_in;
   logic [NUM_W-1:0] counter_ff, counter_in;
   logic             take;

   assign req_if.ready = !stage_valid_ff || push_ready;
   assign take         = req_if.valid && req_if.ready;

   always_comb begin
      counter_in     = counter_ff;
      stage_word_in  = stage_word_ff;
      stage_valid_in = stage_valid_ff && !push_ready;
      if (take) begin
         stage_valid_in           = 1'b1;
         stage_word_in.is_request = (req_if.command == CMD_REQUEST);
         stage_word_in.slot       = req_if.block_slot;
         stage_word_in.size       = req_if.size_value[SIZE_BITS-1:0];
         stage_word_in.number     = '0;
         if (req_if.command == CMD_REQUEST) begin
            counter_in           = counter_ff + NUM_W'(1);
            stage_word_in.number = counter_ff + NUM_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         counter_ff     <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         counter_ff     <= counter_in;
      end
      stage_word_ff <= stage_word_in;
   end

   assign push_valid = stage_valid_ff;
   assign push_word  = stage_word_ff;

endmodule

/* design/fpba_queue.sv */
// Two-entry queue decoupling the front end from the allocation engine.
module fpba_queue import fpba_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     wr_valid,
   input  work_type wr_word,
   output logic     wr_ready,
   output logic     rd_valid,
   output work_type rd_word,
   input  logic     rd_ready
);

   work_type    data_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  fill_ff, fill_in;
   logic        do_wr, do_rd;

   assign wr_ready = (fill_ff != 2'd2);
   assign rd_valid = (fill_ff != 2'd0);
   assign rd_word  = data_ff[rd_ptr_ff];
   assign do_wr    = wr_valid && wr_ready;
   assign do_rd    = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_wr;
      rd_ptr_in = rd_ptr_ff ^ do_rd;
      fill_in   = fill_ff + 2'(do_wr) - 2'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (do_wr) begin
         data_ff[wr_ptr_ff] <= wr_word;
      end
   end

endmodule

/* design/fpba_back.sv */
// Allocation engine: block table, two-level registered selection tree and update.
module fpba_back import fpba_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      pop_valid,
   input  work_type  pop_word,
   output logic      pop_ready,
   fpba_rsp_if.source rsp_if
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_MERGE = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   work_type             cur_ff, cur_in;
   cand_type             grp_ff [GROUPS];
   cand_type             grp_in [GROUPS];
   cand_type             win_ff, win_in;
   logic [SIZE_BITS-1:0] remaining_ff [MAX_BLOCKS];
   logic                 used_ff [MAX_BLOCKS];
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_granted_ff, rsp_granted_in;
   logic [SLOT_W-1:0]    rsp_block_ff, rsp_block_in;
   logic [NUM_W-1:0]     rsp_number_ff, rsp_number_in;
   logic [COUNT_W-1:0]   count_eff;
   logic                 out_free;
   logic                 finish;

   assign count_eff = (cfg.block_count > COUNT_W'(MAX_BLOCKS)) ?
                      COUNT_W'(MAX_BLOCKS) : cfg.block_count;
   assign out_free  = !rsp_valid_ff || rsp_if.ready;
   assign pop_ready = (state_ff == ST_IDLE);
   assign finish    = (state_ff == ST_DONE) && out_free;

   // first level: best candidate of each lane group
   always_comb begin
      cand_type c;
      cand_type acc;
      int       j;
      for (int g = 0; g < GROUPS; g++) begin
         acc = '0;
         for (int l = 0; l < LANES; l++) begin
            j       = g * LANES + l;
            c.idx   = BLK_W'(j);
            c.size  = remaining_ff[j];
            c.valid = (COUNT_W'(j) < count_eff) && (remaining_ff[j] > cur_ff.size) &&
                      (cfg.fit_mode == MODE_FIRST || cfg.fit_mode == MODE_WORST ||
                       (cfg.fit_mode == MODE_BEST && !used_ff[j]));
            acc     = pick_better(acc, c, cfg.fit_mode);
         end
         grp_in[g] = acc;
      end
   end

   always_comb begin
      cand_type acc;
      acc = '0;
      for (int g = 0; g < GROUPS; g++) begin
         acc = pick_better(acc, grp_ff[g], cfg.fit_mode);
      end
      win_in = acc;
   end

   always_comb begin
      state_in = state_ff;
      cur_in   = cur_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               cur_in   = pop_word;
               state_in = pop_word.is_request ? ST_SCAN : ST_DONE;
            end
         end
         ST_SCAN:  state_in = ST_MERGE;
         ST_MERGE: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      rsp_granted_in = rsp_granted_ff;
      rsp_block_in   = rsp_block_ff;
      rsp_number_in  = rsp_number_ff;
      if (finish) begin
         rsp_valid_in   = 1'b1;
         rsp_granted_in = cur_ff.is_request && win_ff.valid;
         rsp_block_in   = (cur_ff.is_request && win_ff.valid) ? SLOT_W'(win_ff.idx) : '0;
         rsp_number_in  = cur_ff.number;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_BLOCKS; i++) begin
            remaining_ff[i] <= '0;
            used_ff[i]      <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (finish) begin
            if (!cur_ff.is_request) begin
               remaining_ff[cur_ff.slot[BLK_W-1:0]] <= cur_ff.size;
               used_ff[cur_ff.slot[BLK_W-1:0]]      <= 1'b0;
            end else if (win_ff.valid) begin
               if (cfg.fit_mode == MODE_BEST) begin
                  used_ff[win_ff.idx] <= 1'b1;
               end else begin
                  remaining_ff[win_ff.idx] <= win_ff.size - cur_ff.size;
               end
            end
         end
      end
      cur_ff         <= cur_in;
      grp_ff         <= grp_in;
      win_ff         <= win_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_block_ff   <= rsp_block_in;
      rsp_number_ff  <= rsp_number_in;
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.granted        = rsp_granted_ff;
   assign rsp_if.chosen_block   = rsp_block_ff;
   assign rsp_if.request_number = rsp_number_ff;

endmodule

/* design/fit_policy_block_allocator_unit.sv */
// Top level of the fit policy block allocator.
// Holds sixteen block sizes loaded by load words and serves allocation request words by
// first, best or worst fit, one response word per input word, in order. A front stage
// numbers requests and feeds a two-entry queue; the engine behind it takes one word at a
// time. A load word goes from issue straight to the table update; a request goes through
// issue, a registered compare of each four-block group, a registered merge of the group
// winners, then the table update and response register load. The response register lets
// the engine take in and scan the next word while a response waits; that word finishes
// once the response is taken. Write fit_mode and block_count only while idle.
module fit_policy_block_allocator_unit import fpba_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   fpba_req_if.sink             req_if,
   fpba_rsp_if.source           rsp_if,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   cfg_type  cfg_ff, cfg_in;
   logic     push_valid, push_ready;
   work_type push_word;
   logic     pop_valid, pop_ready;
   work_type pop_word;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_FIT_MODE:    cfg_in.fit_mode    = csr_wdata[MODE_W-1:0];
            CSR_BLOCK_COUNT: cfg_in.block_count = csr_wdata[COUNT_W-1:0];
            default:         cfg_in             = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   fpba_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .push_valid (push_valid),
      .push_word  (push_word),
      .push_ready (push_ready)
   );

   fpba_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (push_valid),
      .wr_word  (push_word),
      .wr_ready (push_ready),
      .rd_valid (pop_valid),
      .rd_word  (pop_word),
      .rd_ready (pop_ready)
   );

   fpba_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_word  (pop_word),
      .pop_ready (pop_ready),
      .rsp_if    (rsp_if)
   );

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the fit policy block allocator: directed and random words.
module tb_top import fpba_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [MODE_W-1:0] MODE_UNDEFINED = 2'd3;
   localparam int CYCLE_LIMIT = 40_000;
   localparam int RANDOM_WORDS = 420;
   localparam int BURST_WORDS = 40;

   typedef struct packed {
      logic               granted;
      logic [BLK_W-1:0]   chosen_block;
      logic [NUM_W-1:0]   request_number;
   } grant_word_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   fpba_req_if req_if ();
   fpba_rsp_if rsp_if ();

   fit_policy_block_allocator_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   // Shadow of the allocator state
   logic [SIZE_BITS-1:0] blk_size [MAX_BLOCKS];
   logic                 blk_used [MAX_BLOCKS];
   logic [NUM_W-1:0]     req_count;
   logic [MODE_W-1:0]    fit_mode_m;
   logic [COUNT_W-1:0]   blk_count_m;

   grant_word_type expected_grants [$];
   int          fails;
   int          cycles;
   bit          idle_on;
   int          stall_left;

   function automatic grant_word_type predict_allocation(logic cmd, logic [SLOT_W-1:0] slot,
                                                         logic [VALUE_W-1:0] value);
      grant_word_type w;
      logic [SIZE_BITS-1:0] need;
      int pick;
      int span;
      int j;
      w = '0;
      need = value[SIZE_BITS-1:0];
      if (cmd == CMD_LOAD) begin
         blk_size[slot] = need;
         blk_used[slot] = 1'b0;
         return w;
      end
      req_count = req_count + 1'b1;
      w.request_number = req_count;
      span = (blk_count_m > MAX_BLOCKS) ? MAX_BLOCKS : int'(blk_count_m);
      pick = -1;
      for (j = 0; j < span; j++) begin
         if (blk_size[j] > need) begin
            case (fit_mode_m)
               MODE_FIRST: begin
                  if (pick < 0) pick = j;
               end
               MODE_BEST: begin
                  if (!blk_used[j] && (pick < 0 || blk_size[j] < blk_size[pick])) pick = j;
               end
               MODE_WORST: begin
                  if (pick < 0 || blk_size[j] > blk_size[pick]) pick = j;
               end
               default: ;
            endcase
         end
      end
      if (pick >= 0) begin
         // best fit only marks the block; the others carve the request out of it
         if (fit_mode_m == MODE_BEST) blk_used[pick] = 1'b1;
         else blk_size[pick] = blk_size[pick] - need;
         w.granted = 1'b1;
         w.chosen_block = pick[BLK_W-1:0];
      end
      return w;
   endfunction

   function automatic void check_grant();
      grant_word_type want;
      if (expected_grants.size() == 0) begin
         $error("unexpected response word: granted %0d chosen_block %0d request_number %0d",
                rsp_if.granted, rsp_if.chosen_block, rsp_if.request_number);
         fails++;
         return;
      end
      want = expected_grants.pop_front();
      if (rsp_if.granted !== want.granted) begin
         $error("granted: expected %0d, actual %0d", want.granted, rsp_if.granted);
         fails++;
      end
      if (rsp_if.chosen_block !== want.chosen_block) begin
         $error("chosen_block: expected %0d, actual %0d", want.chosen_block,
                rsp_if.chosen_block);
         fails++;
      end
      if (rsp_if.request_number !== want.request_number) begin
         $error("request_number: expected %0d, actual %0d", want.request_number,
                rsp_if.request_number);
         fails++;
      end
   endfunction

   // Response side: check accepted words, stall in short bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) check_grant();
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 2);
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic send_word(logic cmd, logic [SLOT_W-1:0] slot, logic [VALUE_W-1:0] value);
      grant_word_type w;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.command    <= cmd;
      req_if.block_slot <= slot;
      req_if.size_value <= value;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      w = predict_allocation(cmd, slot, value);
      expected_grants = {expected_grants, w};
   endtask

   task automatic wait_for_idle();
      req_if.valid <= 1'b0;
      while (expected_grants.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx == CSR_FIT_MODE) fit_mode_m = data[MODE_W-1:0];
      else blk_count_m = data[COUNT_W-1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [VALUE_W-1:0] rand_size(int cap);
      int r;
      r = $urandom_range(0, 9);
      if (r < 7) return VALUE_W'($urandom_range(0, cap));
      if (r < 9) return VALUE_W'($urandom);
      return ($urandom_range(0, 1) != 0) ? '1 : '0;
   endfunction

   task automatic test_reset_defaults();
      // no blocks in use out of reset, so nothing is granted
      send_word(CMD_REQUEST, 4'h0, 16'h0000);
   endtask

   task automatic test_first_fit();
      wait_for_idle();
      write_csr(CSR_FIT_MODE, CSR_W'(MODE_FIRST));
      write_csr(CSR_BLOCK_COUNT, 5'd4);
      send_word(CMD_LOAD, 4'd0, 16'd10);
      send_word(CMD_LOAD, 4'd1, 16'd50);
      send_word(CMD_LOAD, 4'd2, 16'd50);
      send_word(CMD_LOAD, 4'd3, 16'd5);
      send_word(CMD_REQUEST, 4'd0, 16'd10);   // equal size is not eligible
      send_word(CMD_REQUEST, 4'd0, 16'd45);
      send_word(CMD_REQUEST, 4'd0, 16'd0);
      send_word(CMD_REQUEST, 4'hF, 16'hFFFF);
   endtask

   task automatic test_worst_fit();
      wait_for_idle();
      write_csr(CSR_FIT_MODE, CSR_W'(MODE_WORST));
      send_word(CMD_LOAD, 4'd3, 16'd40);      // ties block 1, lower index wins
      send_word(CMD_REQUEST, 4'd0, 16'd1);
   endtask

   task automatic test_best_fit();
      wait_for_idle();
      write_csr(CSR_FIT_MODE, CSR_W'(MODE_BEST));
      send_word(CMD_REQUEST, 4'd0, 16'd4);
      send_word(CMD_REQUEST, 4'd0, 16'd4);    // smallest is now used
      send_word(CMD_REQUEST, 4'd0, 16'd100);
   endtask

   task automatic test_mixed_modes();
      wait_for_idle();
      write_csr(CSR_FIT_MODE, CSR_W'(MODE_FIRST));
      send_word(CMD_REQUEST, 4'd0, 16'd4);    // used marks do not apply here
   endtask

   task automatic test_undefined_mode();
      wait_for_idle();
      write_csr(CSR_FIT_MODE, CSR_W'(MODE_UNDEFINED));
      send_word(CMD_REQUEST, 4'd0, 16'd0);
   endtask

   task automatic test_block_count_limits();
      wait_for_idle();
      write_csr(CSR_FIT_MODE, CSR_W'(MODE_FIRST));
      write_csr(CSR_BLOCK_COUNT, 5'd31);      // clamps to all blocks
      send_word(CMD_LOAD, 4'hF, 16'hFFFF);
      send_word(CMD_REQUEST, 4'hA, 16'hFFFE);
      wait_for_idle();
      write_csr(CSR_BLOCK_COUNT, 5'd0);
      send_word(CMD_REQUEST, 4'h5, 16'h0000);
   endtask

   task automatic test_random_mix();
      int sent;
      int pick;
      int span;
      int s;
      logic [MODE_W-1:0] mode;
      logic [COUNT_W-1:0] count;
      sent = 0;
      while (sent < RANDOM_WORDS) begin
         pick = $urandom_range(0, 9);
         mode = (pick < 3) ? MODE_FIRST : (pick < 6) ? MODE_BEST :
                (pick < 9) ? MODE_WORST : MODE_UNDEFINED;
         pick = $urandom_range(0, 7);
         count = (pick == 0) ? 5'd0 : (pick == 1) ? 5'd16 : (pick == 2) ? 5'd31 :
                 (pick == 3) ? 5'd1 : COUNT_W'($urandom_range(2, 16));
         wait_for_idle();
         idle_on = ($urandom_range(0, 3) != 0);
         write_csr(CSR_FIT_MODE, CSR_W'(mode));
         write_csr(CSR_BLOCK_COUNT, count);
         span = (count > MAX_BLOCKS) ? MAX_BLOCKS : int'(count);
         // fill every block in use, then a run of mostly requests
         for (s = 0; s < span; s++) send_word(CMD_LOAD, SLOT_W'(s), rand_size(1000));
         repeat (30) begin
            if ($urandom_range(0, 4) == 0)
               send_word(CMD_LOAD, SLOT_W'($urandom_range(0, 15)), rand_size(1000));
            else
               send_word(CMD_REQUEST, SLOT_W'($urandom), rand_size(300));
         end
         sent += span + 30;
      end
   endtask

   task automatic test_back_to_back();
      wait_for_idle();
      idle_on = 1'b0;
      write_csr(CSR_FIT_MODE, CSR_W'(MODE_WORST));
      write_csr(CSR_BLOCK_COUNT, 5'd16);
      repeat (BURST_WORDS) begin
         if ($urandom_range(0, 3) == 0)
            send_word(CMD_LOAD, SLOT_W'($urandom_range(0, 15)), rand_size(1000));
         else
            send_word(CMD_REQUEST, SLOT_W'($urandom), rand_size(300));
      end
   endtask

   initial begin
      req_if.valid      <= 1'b0;
      req_if.command    <= CMD_LOAD;
      req_if.block_slot <= '0;
      req_if.size_value <= '0;
      csr_wr_en         <= 1'b0;
      csr_index         <= CSR_FIT_MODE;
      csr_wdata         <= '0;
      fails = 0;
      cycles = 0;
      idle_on = 1'b1;
      req_count = '0;
      fit_mode_m = MODE_FIRST;
      blk_count_m = '0;
      foreach (blk_size[i]) begin
         blk_size[i] = '0;
         blk_used[i] = 1'b0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_first_fit();
      test_worst_fit();
      test_best_fit();
      test_mixed_modes();
      test_undefined_mode();
      test_block_count_limits();
      test_random_mix();
      test_back_to_back();

      wait_for_idle();
      repeat (12) @(posedge clock);
      if (fails == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
